>>> hw/rtl/c2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c2s_pkg;
  localparam int AngW = 32;
  localparam logic [AngW-1:0] HalfTurn = 32'h8000_0000;
  localparam logic [AngW-1:0] QuarterTurn = 32'h4000_0000;
  localparam int Prescale = 24;

  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      5'd24: v = 32'd40;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd2;
      5'd29: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one restoring square-root step per cell; sidebands ride along
module c2s_sqrt_cell #(
  parameter int W = 34,
  parameter int R = 17,
  parameter int SHIFT = 0,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [R-1:0]  res_i,
  input  wire logic [SW-1:0] side_i,
  output logic      [W-1:0]  rem_o,
  output logic      [R-1:0]  res_o,
  output logic      [SW-1:0] side_o
);
  logic [W+1:0] trial;
  logic [W-1:0] rem_next;
  always_comb begin
    trial = (W+2)'(rem_i[W-1:2*SHIFT])
            - {{(W+2-R-2){1'b0}}, res_i, 2'b01};
    rem_next = rem_i;
    if (!trial[W+1]) begin
      rem_next[W-1:2*SHIFT] = trial[W-1-2*SHIFT:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      rem_o <= rem_next;
      res_o <= {res_i[R-2:0], !trial[W+1]};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/c2s_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one vectoring CORDIC rotation per cell
module c2s_cordic_cell #(
  parameter int W = 60,
  parameter int IDX = 0,
  parameter int SW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [W-1:0]   a_i,
  input  wire logic signed [W-1:0]   b_i,
  input  wire logic [c2s_pkg::AngW-1:0] ang_i,
  input  wire logic [SW-1:0]         side_i,
  output logic signed [W-1:0]        a_o,
  output logic signed [W-1:0]        b_o,
  output logic [c2s_pkg::AngW-1:0]   ang_o,
  output logic [SW-1:0]              side_o
);
  logic signed [W-1:0] da, db;
  logic [c2s_pkg::AngW-1:0] t;
  always_comb begin
    da = b_i >>> IDX;
    db = a_i >>> IDX;
    t  = c2s_pkg::atan_lut(5'(IDX));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      if (!b_i[W-1]) begin
        a_o <= a_i + da;
        b_o <= b_i - db;
        ang_o <= ang_i + t;
      end else begin
        a_o <= a_i - da;
        b_o <= b_i + db;
        ang_o <= ang_i - t;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/cartesian_to_spherical_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Cartesian to spherical converter. One vector (x_in, y_in, z_in) enters per
// cycle and leaves as radius, polar_angle and azimuth (65536 = one turn). The
// path is a chain of cells: a register stage for the squares, 33 square-root
// cells that form the radius and the xy length, a CORDIC setup stage, then
// ITERATIONS CORDIC cells that form both angles in parallel, then one output
// stage. The whole chain advances together and stalls only while the output
// is held.
module cartesian_to_spherical_core #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  valid_in,
  output logic                       ready_in,
  input  wire logic [DATA_WIDTH-1:0] x_in,
  input  wire logic [DATA_WIDTH-1:0] y_in,
  input  wire logic [DATA_WIDTH-1:0] z_in,
  output logic                       valid_out,
  input  wire logic                  ready_out,
  output logic [DATA_WIDTH-1:0]      radius,
  output logic [15:0]                polar_angle,
  output logic [15:0]                azimuth
);
  localparam int DW   = DATA_WIDTH;
  localparam int FRAC = (DW < 32) ? 32 - DW : 0;
  localparam int SQW  = 2*DW + 2;          // covers x2+y2+z2
  localparam int SQR  = DW + 1;            // root bits of sall
  localparam int RW   = 2*DW + 2*FRAC + 2; // sxy << 2frac
  localparam int RR   = DW + FRAC + 1;
  localparam int NS   = RR;                // sqrt cells (covers both)
  localparam int CW   = DW + FRAC + c2s_pkg::Prescale + 4;
  localparam int AW   = c2s_pkg::AngW;
  localparam int LAT  = NS + ITERATIONS + 2;
  // sideband: sign x, sign y, x==0, y==0, z==0, sxy==0, z<0, x, y, z
  localparam int SB   = 7 + 3*DW;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !valid_out || ready_out;
  assign ready_in = en;

  // stage 0: squares
  logic signed [DW-1:0] xs, ys, zs;
  logic signed [2*DW-1:0] x2, y2, z2;
  logic [2*DW:0] sxy_c;
  logic [SQW-1:0] sall_c;
  logic [SB-1:0] side0;
  always_comb begin
    xs = signed'(x_in);
    ys = signed'(y_in);
    zs = signed'(z_in);
    x2 = xs * xs;
    y2 = ys * ys;
    z2 = zs * zs;
    sxy_c = (2*DW+1)'(unsigned'(x2)) + (2*DW+1)'(unsigned'(y2));
    sall_c = SQW'(sxy_c) + SQW'(unsigned'(z2));
    side0 = {xs[DW-1], ys[DW-1], xs == '0, ys == '0, zs == '0, sxy_c == '0,
             zs[DW-1], x_in, y_in, z_in};
  end

  logic [SQW-1:0] s_rem [NS+1];
  logic [SQR-1:0] s_res [NS+1];
  logic [RW-1:0]  p_rem [NS+1];
  logic [RR-1:0]  p_res [NS+1];
  logic [SB-1:0]  s_sb  [NS+1];
  logic [SQW-1:0] sall0;

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem[0] <= sall_c;
      s_res[0] <= '0;
      p_rem[0] <= RW'(sxy_c) << (2*FRAC);
      p_res[0] <= '0;
      s_sb[0]  <= side0;
      sall0    <= sall_c;
    end
  end

  logic [SQW-1:0] sall_d [NS+1];
  assign sall_d[0] = sall0;

  for (genvar k = 0; k < NS; k++) begin : g_sq
    localparam int SH = NS - 1 - k;
    if (SH < SQR) begin : g_a
      c2s_sqrt_cell #(.W(SQW), .R(SQR), .SHIFT(SH), .SW(SQW)) u_a (
        .clk, .en, .rem_i(s_rem[k]), .res_i(s_res[k]), .side_i(sall_d[k]),
        .rem_o(s_rem[k+1]), .res_o(s_res[k+1]), .side_o(sall_d[k+1]));
    end else begin : g_ap
      always_ff @(posedge clk) begin
        if (en) begin
          s_rem[k+1] <= s_rem[k];
          s_res[k+1] <= s_res[k];
          sall_d[k+1] <= sall_d[k];
        end
      end
    end
    c2s_sqrt_cell #(.W(RW), .R(RR), .SHIFT(SH), .SW(SB)) u_p (
      .clk, .en, .rem_i(p_rem[k]), .res_i(p_res[k]), .side_i(s_sb[k]),
      .rem_o(p_rem[k+1]), .res_o(p_res[k+1]), .side_o(s_sb[k+1]));
  end

  // rounding of roots and CORDIC setup
  logic [SQR:0] r_rnd;
  logic [RR:0]  rho_rnd;
  logic [SB-1:0] sb;
  logic signed [DW-1:0] xv, yv, zv;
  logic signed [CW-1:0] aa0, ab0, pa0, pb0;
  logic [AW-1:0] aang0, pang0;
  logic [DW-1:0] rad_c;
  always_comb begin
    sb = s_sb[NS];
    xv = signed'(sb[3*DW-1:2*DW]);
    yv = signed'(sb[2*DW-1:DW]);
    zv = signed'(sb[DW-1:0]);
    // remainder > res means round up
    r_rnd = {1'b0, s_res[NS]} +
            (SQR+1)'(s_rem[NS] > SQW'(s_res[NS]));
    rho_rnd = {1'b0, p_res[NS]} +
              (RR+1)'(p_rem[NS] > RW'(p_res[NS]));
    rad_c = (r_rnd > (SQR+1)'({DW{1'b1}})) ? {DW{1'b1}} : DW'(r_rnd);
    aang0 = '0;
    aa0 = CW'(xv) <<< c2s_pkg::Prescale;
    ab0 = CW'(yv) <<< c2s_pkg::Prescale;
    if (xv[DW-1]) begin
      aa0 = -aa0; ab0 = -ab0; aang0 = c2s_pkg::HalfTurn;
    end
    pang0 = '0;
    pa0 = (CW'(zv) <<< FRAC) <<< c2s_pkg::Prescale;
    pb0 = CW'(rho_rnd) <<< c2s_pkg::Prescale;
    if (zv[DW-1]) begin
      pa0 = -pa0; pb0 = -pb0; pang0 = c2s_pkg::HalfTurn;
    end
  end

  localparam int CSB = 7 + DW;
  logic signed [CW-1:0] ca [ITERATIONS+1], cb [ITERATIONS+1];
  logic signed [CW-1:0] qa [ITERATIONS+1], qb [ITERATIONS+1];
  logic [AW-1:0] cang [ITERATIONS+1], qang [ITERATIONS+1];
  logic [CSB-1:0] csb [ITERATIONS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ca[0] <= aa0; cb[0] <= ab0; cang[0] <= aang0;
      qa[0] <= pa0; qb[0] <= pb0; qang[0] <= pang0;
      csb[0] <= {sb[SB-1:3*DW], rad_c};
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_co
    c2s_cordic_cell #(.W(CW), .IDX((i < 31) ? i : 31), .SW(CSB)) u_az (
      .clk, .en, .a_i(ca[i]), .b_i(cb[i]), .ang_i(cang[i]), .side_i(csb[i]),
      .a_o(ca[i+1]), .b_o(cb[i+1]), .ang_o(cang[i+1]), .side_o(csb[i+1]));
    c2s_cordic_cell #(.W(CW), .IDX((i < 31) ? i : 31), .SW(1)) u_po (
      .clk, .en, .a_i(qa[i]), .b_i(qb[i]), .ang_i(qang[i]), .side_i(1'b0),
      .a_o(qa[i+1]), .b_o(qb[i+1]), .ang_o(qang[i+1]), .side_o());
  end

  // final selection
  logic [CSB-1:0] fs;
  logic [AW:0] az_r, po_r;
  logic [AW-1:0] pang;
  logic [15:0] az_c, po_c;
  always_comb begin
    fs = csb[ITERATIONS];
    az_r = {1'b0, cang[ITERATIONS]} + (AW+1)'(32'h8000);
    if (fs[DW+3])
      az_c = fs[DW+6] ? 16'd32768 : 16'd0;
    else if (fs[DW+4])
      az_c = fs[DW+5] ? 16'd49152 : 16'd16384;
    else
      az_c = az_r[31:16];
    pang = qang[ITERATIONS];
    if (pang >= c2s_pkg::HalfTurn + c2s_pkg::QuarterTurn)
      pang = '0;
    else if (pang > c2s_pkg::HalfTurn)
      pang = c2s_pkg::HalfTurn;
    po_r = {1'b0, pang} + (AW+1)'(32'h8000);
    po_c = (po_r[AW:16] > 17'd32768) ? 16'd32768 : po_r[31:16];
    if (fs[DW+1])
      po_c = fs[DW] ? 16'd32768 : 16'd0;
    else if (fs[DW+2])
      po_c = 16'd16384;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      valid_out <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], valid_in};
      valid_out <= vld[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      radius <= fs[DW-1:0];
      polar_angle <= po_c;
      azimuth <= az_c;
    end
  end
  logic unused_v;
  assign unused_v = ^sall_d[NS] ^ ^ca[ITERATIONS] ^ ^cb[ITERATIONS]
                    ^ ^qa[ITERATIONS] ^ ^qb[ITERATIONS] ^ r_rnd[SQR] ^ rho_rnd[RR];
endmodule
`default_nettype wire

>>> hw/rtl/c2s_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module c2s_port_props #(
  parameter int DATA_WIDTH = 16
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  valid_in,
  input wire logic                  ready_in,
  input wire logic                  valid_out,
  input wire logic                  ready_out,
  input wire logic [DATA_WIDTH-1:0] radius,
  input wire logic [15:0]           polar_angle,
  input wire logic [15:0]           azimuth
);
  a_polar_range: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> polar_angle <= 16'd32768) else $error("polar out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(radius)
    && $stable(azimuth) && $stable(polar_angle)) else $error("output not held");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !valid_out |-> ready_in) else $error("stalled with empty output");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    valid_out && radius == '0 |-> azimuth == '0 && polar_angle == '0)
    else $error("zero vector angles");
  logic unused_c;
  assign unused_c = valid_in;
endmodule

bind cartesian_to_spherical_core c2s_port_props #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk, .rst, .valid_in, .ready_in, .valid_out, .ready_out,
  .radius, .polar_angle, .azimuth);
`default_nettype wire
